// ----- sv/clim_pkg.sv -----
package clim_pkg;

    localparam int unsigned IdxW = 5;
    localparam int unsigned ValW = 32;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_PREPARE = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;

    typedef struct packed {
        logic [1:0]      op;
        logic [IdxW-1:0] entry_index;
        logic [ValW-1:0] entry_length;
        logic [IdxW-1:0] entry_partner;
        logic [ValW-1:0] point;
    } t_in_item;

    typedef struct packed {
        logic [IdxW-1:0] interval_index;
        logic [ValW-1:0] image_point;
        logic            on_division_point;
    } t_out_item;

endpackage

// ----- sv/circle_leaf_interval_map_core.sv -----
// Piecewise circle map built from loaded intervals. A query scans the n active division
// points one per cycle. A prepare walks the tables with one read and one write port per
// table and one shared restoring divider that yields one quotient bit a cycle; a zero
// length total skips the divider. The block takes one transaction at a time; a
// finished result sits in an output register while the next transaction is accepted.
module circle_leaf_interval_map_core
    import clim_pkg::*;
#(
    parameter int unsigned MAX_INTERVALS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [5:0] i_cfg_wdata,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int unsigned AW = (MAX_INTERVALS > 2) ? $clog2(MAX_INTERVALS) : 1;
    localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_AV1  = 4'd1;
    localparam logic [3:0] S_AV2  = 4'd2;
    localparam logic [3:0] S_AV3  = 4'd3;
    localparam logic [3:0] S_AV4  = 4'd4;
    localparam logic [3:0] S_SUM  = 4'd5;
    localparam logic [3:0] S_NL   = 4'd6;
    localparam logic [3:0] S_ND   = 4'd7;
    localparam logic [3:0] S_CLR  = 4'd8;
    localparam logic [3:0] S_OF1  = 4'd9;
    localparam logic [3:0] S_OF2  = 4'd10;
    localparam logic [3:0] S_OF3  = 4'd11;
    localparam logic [3:0] S_QS   = 4'd12;
    localparam logic [3:0] S_QO   = 4'd13;
    localparam logic [3:0] S_FIN  = 4'd14;

    logic [31:0] mem_len [MAX_INTERVALS];
    logic [4:0]  mem_par [MAX_INTERVALS];
    logic [31:0] mem_bnd [MAX_INTERVALS];
    logic [31:0] mem_off [MAX_INTERVALS];

    logic [31:0] r_len_q, r_bnd_q, r_off_q;
    logic [4:0]  r_par_q;

    logic          len_we, par_we, bnd_we, off_we;
    logic [AW-1:0] len_ra, len_wa, par_ra, par_wa, bnd_ra, bnd_wa, off_ra, off_wa;
    logic [31:0]   len_wd, bnd_wd, off_wd;
    logic [4:0]    par_wd;

    logic [3:0]  r_state, n_state;
    logic [5:0]  r_nint;
    logic [CW-1:0] r_i, n_i, r_sel, n_sel;
    logic [4:0]  r_p, n_p;
    logic [31:0] r_a, n_a, r_q, n_q, r_acc, n_acc, r_img, n_img;
    logic [36:0] r_total, n_total;
    logic [37:0] r_rem, n_rem;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_hit, n_hit, r_stop, n_stop;
    t_in_item    r_item, n_item;
    logic        r_ov;
    t_out_item   r_out;

    logic [CW-1:0] n_act;
    logic [8:0]    cfg9, n9, i9, p9, ip9;
    logic          last_i, accept, fin_go, p_ok;
    logic [32:0]   avg_sum;
    logic [37:0]   rem2;
    logic [31:0]   q_next;
    logic [CW-1:0] i_inc;
    logic [8:0]    sel9;

    always_comb begin
        cfg9 = 9'(r_nint);
        if (r_nint < 6'd2) begin
            n_act = CW'(2);
        end else if (cfg9 > 9'(MAX_INTERVALS)) begin
            n_act = CW'(MAX_INTERVALS);
        end else begin
            n_act = CW'(r_nint);
        end
    end

    assign n9      = 9'(n_act);
    assign i9      = 9'(r_i);
    assign p9      = 9'(r_p);
    assign ip9     = 9'(i_in_data.entry_index);
    assign i_inc   = r_i + CW'(1);
    assign last_i  = (i9 + 9'd1) >= n9;
    assign p_ok    = p9 < n9;
    assign avg_sum = {1'b0, r_a} + {1'b0, r_len_q};
    assign rem2    = {r_rem[36:0], 1'b0};
    assign q_next  = {r_q[30:0], (rem2 >= {1'b0, r_total})};
    assign accept  = i_in_valid && !o_in_stall;
    assign fin_go  = !r_ov || !i_out_stall;
    assign sel9    = 9'(r_sel);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_sel   = r_sel;
        n_p     = r_p;
        n_a     = r_a;
        n_q     = r_q;
        n_acc   = r_acc;
        n_img   = r_img;
        n_total = r_total;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_hit   = r_hit;
        n_stop  = r_stop;
        n_item  = r_item;
        len_we = 1'b0; len_wa = r_i[AW-1:0]; len_wd = '0; len_ra = r_i[AW-1:0];
        par_we = 1'b0; par_wa = r_i[AW-1:0]; par_wd = '0; par_ra = r_i[AW-1:0];
        bnd_we = 1'b0; bnd_wa = r_i[AW-1:0]; bnd_wd = '0; bnd_ra = r_i[AW-1:0];
        off_we = 1'b0; off_wa = r_i[AW-1:0]; off_wd = '0; off_ra = r_i[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_item = i_in_data;
                    n_i    = '0;
                    n_sel  = '0;
                    n_img  = '0;
                    n_hit  = 1'b0;
                    n_stop = 1'b0;
                    case (i_in_data.op)
                        OP_LOAD: begin
                            if (ip9 < 9'(MAX_INTERVALS)) begin
                                len_we = 1'b1;
                                len_wa = AW'(i_in_data.entry_index);
                                len_wd = i_in_data.entry_length;
                                par_we = 1'b1;
                                par_wa = AW'(i_in_data.entry_index);
                                par_wd = i_in_data.entry_partner;
                            end
                            n_state = S_FIN;
                        end
                        OP_PREPARE: begin
                            par_ra  = '0;
                            n_state = S_AV1;
                        end
                        OP_QUERY: begin
                            bnd_ra  = '0;
                            n_state = S_QS;
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            // pair averaging, in place, ascending index
            S_AV1: begin
                n_p     = r_par_q;
                len_ra  = r_i[AW-1:0];
                n_state = S_AV2;
            end
            S_AV2: begin
                n_a     = r_len_q;
                len_ra  = AW'(r_p);
                n_state = S_AV3;
            end
            S_AV3, S_AV4: begin
                if (r_state == S_AV3 && p9 > i9 && p_ok) begin
                    len_we  = 1'b1;
                    len_wd  = avg_sum[32:1];
                    n_a     = avg_sum[32:1];
                    n_state = S_AV4;
                end else begin
                    if (r_state == S_AV4) begin
                        len_we = 1'b1;
                        len_wa = AW'(r_p);
                        len_wd = r_a;
                    end
                    if (last_i) begin
                        n_i     = '0;
                        n_total = '0;
                        len_ra  = '0;
                        n_state = S_SUM;
                    end else begin
                        n_i     = i_inc;
                        par_ra  = i_inc[AW-1:0];
                        n_state = S_AV1;
                    end
                end
            end
            S_SUM: begin
                n_total = r_total + 37'(r_len_q);
                if (last_i) begin
                    n_i     = '0;
                    n_acc   = '0;
                    len_ra  = '0;
                    n_state = S_NL;
                end else begin
                    n_i     = i_inc;
                    len_ra  = i_inc[AW-1:0];
                    n_state = S_SUM;
                end
            end
            // normalize one entry and lay down its division point
            S_NL, S_ND: begin
                if (r_state == S_NL && r_total != '0) begin
                    n_q     = '0;
                    n_cnt   = '0;
                    n_rem   = ({5'd0, r_len_q} >= r_total) ?
                              38'({5'd0, r_len_q} - r_total) : {6'd0, r_len_q};
                    n_state = S_ND;
                end else if (r_state == S_ND && r_cnt != 5'd31) begin
                    n_rem   = (rem2 >= {1'b0, r_total}) ? (rem2 - {1'b0, r_total}) : rem2;
                    n_q     = q_next;
                    n_cnt   = r_cnt + 5'd1;
                end else begin
                    len_we = 1'b1;
                    len_wd = (r_state == S_ND) ? q_next : 32'd0;
                    bnd_we = 1'b1;
                    bnd_wd = r_acc;
                    n_acc  = r_acc + len_wd;
                    if (last_i) begin
                        n_i     = n_act;
                        n_state = (n9 >= 9'(MAX_INTERVALS)) ? S_OF1 : S_CLR;
                        if (n9 >= 9'(MAX_INTERVALS)) begin
                            n_i    = '0;
                            par_ra = '0;
                        end
                    end else begin
                        n_i     = i_inc;
                        len_ra  = i_inc[AW-1:0];
                        n_state = S_NL;
                    end
                end
            end
            S_CLR: begin
                bnd_we = 1'b1;
                off_we = 1'b1;
                if ((i9 + 9'd1) >= 9'(MAX_INTERVALS)) begin
                    n_i     = '0;
                    par_ra  = '0;
                    n_state = S_OF1;
                end else begin
                    n_i = i_inc;
                end
            end
            S_OF1: begin
                n_p     = r_par_q;
                bnd_ra  = AW'(r_par_q);
                n_state = S_OF2;
            end
            S_OF2: begin
                n_a     = p_ok ? r_bnd_q : 32'd0;
                bnd_ra  = last_i ? '0 : i_inc[AW-1:0];
                n_state = S_OF3;
            end
            S_OF3: begin
                off_we = 1'b1;
                off_wd = r_a + r_bnd_q;
                if (last_i) begin
                    n_sel   = '0;
                    n_img   = '0;
                    n_hit   = 1'b0;
                    n_state = S_FIN;
                end else begin
                    n_i     = i_inc;
                    par_ra  = i_inc[AW-1:0];
                    n_state = S_OF1;
                end
            end
            S_QS: begin
                if (r_bnd_q == r_item.point) begin
                    n_hit = 1'b1;
                end
                if (r_i != '0 && !r_stop) begin
                    if (r_bnd_q < r_item.point) begin
                        n_sel = r_i;
                    end else begin
                        n_stop = 1'b1;
                    end
                end
                if (last_i) begin
                    off_ra  = n_sel[AW-1:0];
                    n_state = S_QO;
                end else begin
                    n_i     = i_inc;
                    bnd_ra  = i_inc[AW-1:0];
                end
            end
            S_QO: begin
                n_img   = r_off_q - r_item.point;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (fin_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (len_we) begin
            mem_len[len_wa] <= len_wd;
        end
        if (par_we) begin
            mem_par[par_wa] <= par_wd;
        end
        if (bnd_we) begin
            mem_bnd[bnd_wa] <= bnd_wd;
        end
        if (off_we) begin
            mem_off[off_wa] <= off_wd;
        end
        r_len_q <= mem_len[len_ra];
        r_par_q <= mem_par[par_ra];
        r_bnd_q <= mem_bnd[bnd_ra];
        r_off_q <= mem_off[off_ra];
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_sel  <= n_sel;
        r_p    <= n_p;
        r_a    <= n_a;
        r_q    <= n_q;
        r_acc  <= n_acc;
        r_img  <= n_img;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        r_hit  <= n_hit;
        r_stop <= n_stop;
        r_item <= n_item;
        if (r_state == S_FIN && fin_go) begin
            r_out.interval_index    <= sel9[4:0];
            r_out.image_point       <= r_img;
            r_out.on_division_point <= r_hit;
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nint  <= 6'd2;
            r_total <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            if (i_cfg_we) begin
                r_nint <= i_cfg_wdata;
            end
            // hold the result until the far side takes the transaction
            if (r_state == S_FIN && fin_go) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule

// ----- tb/tb_circle_leaf_interval_map_core.sv -----
module tb_circle_leaf_interval_map_core;
    import clim_pkg::*;

    localparam int unsigned NumEntries = 32;
    localparam int unsigned SettleCycles = 40;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_we;
    logic [5:0] i_cfg_wdata;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    circle_leaf_interval_map_core #(.MAX_INTERVALS(NumEntries)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Shadow copy of the interval tables
    logic [31:0] len_tab [NumEntries];
    logic [4:0]  partner_tab [NumEntries];
    logic [31:0] bound_tab [NumEntries];
    logic [31:0] offset_tab [NumEntries];
    logic [36:0] len_sum;
    logic [5:0]  count_reg;

    t_out_item expected_results[$];
    int unsigned fail_count;
    int unsigned burst_left;
    int unsigned rx_hold_cycles;
    bit          rx_quiet;

    function automatic int unsigned active_count();
        int unsigned n;
        n = count_reg;
        if (n < 2) n = 2;
        if (n > NumEntries) n = NumEntries;
        return n;
    endfunction

    task automatic build_tables();
        int unsigned n;
        logic [32:0] pair_sum;
        logic [63:0] quo;
        logic [31:0] pb;
        int unsigned nx;
        n = active_count();
        for (int unsigned i = 0; i < n; i++) begin
            if (partner_tab[i] > i && partner_tab[i] < n) begin
                pair_sum = {1'b0, len_tab[i]} + {1'b0, len_tab[partner_tab[i]]};
                len_tab[i] = pair_sum[32:1];
                len_tab[partner_tab[i]] = pair_sum[32:1];
            end
        end
        len_sum = '0;
        for (int unsigned i = 0; i < n; i++) len_sum += {5'b0, len_tab[i]};
        for (int unsigned i = 0; i < n; i++) begin
            if (len_sum == 0) begin
                len_tab[i] = '0;
            end else begin
                quo = {len_tab[i], 32'b0} / {27'b0, len_sum};
                len_tab[i] = quo[31:0];
            end
        end
        bound_tab[0] = '0;
        for (int unsigned i = 0; i + 1 < n; i++) bound_tab[i+1] = bound_tab[i] + len_tab[i];
        for (int unsigned i = n; i < NumEntries; i++) begin
            bound_tab[i] = '0;
            offset_tab[i] = '0;
        end
        for (int unsigned i = 0; i < n; i++) begin
            pb = (partner_tab[i] < n) ? bound_tab[partner_tab[i]] : '0;
            nx = (i + 1 < n) ? i + 1 : 0;
            offset_tab[i] = pb + bound_tab[nx];
        end
    endtask

    task automatic predict_transaction(input t_in_item it, output t_out_item res);
        int unsigned n;
        int unsigned i;
        res = '0;
        case (it.op)
            OP_LOAD: begin
                len_tab[it.entry_index] = it.entry_length;
                partner_tab[it.entry_index] = it.entry_partner;
            end
            OP_PREPARE: build_tables();
            OP_QUERY: begin
                n = active_count();
                i = 0;
                while (i + 1 < n && bound_tab[i+1] < it.point) i++;
                for (int unsigned k = 0; k < n; k++)
                    if (bound_tab[k] == it.point) res.on_division_point = 1'b1;
                res.interval_index = i[4:0];
                res.image_point = offset_tab[i] - it.point;
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input t_in_item it);
        t_out_item res;
        logic stalled;
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_data <= it;
        i_in_valid <= 1'b1;
        do begin
            @(negedge i_clk);
            stalled = o_in_stall;
            @(posedge i_clk);
        end while (stalled);
        predict_transaction(it, res);
        expected_results = {expected_results, res};
    endtask

    task automatic go_idle();
        @(posedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [5:0] value);
        go_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        count_reg = value;
    endtask

    function automatic t_in_item make_load(input logic [4:0] idx, input logic [31:0] len,
                                           input logic [4:0] partner);
        t_in_item it;
        it = '0;
        it.op = OP_LOAD;
        it.entry_index = idx;
        it.entry_length = len;
        it.entry_partner = partner;
        it.point = $urandom;
        return it;
    endfunction

    function automatic t_in_item make_op(input logic [1:0] op, input logic [31:0] pt);
        t_in_item it;
        it = '0;
        it.op = op;
        it.entry_index = 5'($urandom);
        it.entry_length = $urandom;
        it.entry_partner = 5'($urandom);
        it.point = pt;
        return it;
    endfunction

    // Query points at or near the division points, plus extremes and random ones, hit the boundary rules
    function automatic logic [31:0] pick_point();
        int unsigned k;
        k = $urandom_range(0, active_count() - 1);
        case ($urandom_range(0, 5))
            0: return bound_tab[k];
            1: return bound_tab[k];
            2: return bound_tab[k] + 32'd1;
            3: return bound_tab[k] - 32'd1;
            4: return ($urandom_range(0, 1) != 0) ? 32'h0 : 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_full_load();
        for (int unsigned i = 0; i < NumEntries; i++)
            send_item(make_load(i[4:0], $urandom, i[4:0] ^ 5'd1));
        send_item(make_op(OP_PREPARE, $urandom));
        send_item(make_op(OP_QUERY, 32'h0));
        send_item(make_op(OP_QUERY, 32'hFFFF_FFFF));
        send_item(make_op(OP_QUERY, bound_tab[1]));
        send_item(make_op(OP_UNUSED, $urandom));
    endtask

    task automatic test_zero_total();
        send_item(make_load(5'd0, 32'h0, 5'd1));
        send_item(make_load(5'd1, 32'h0, 5'd0));
        send_item(make_op(OP_PREPARE, 32'h0));
        send_item(make_op(OP_QUERY, 32'h0));
        send_item(make_op(OP_QUERY, 32'h8000_0000));
    endtask

    task automatic test_full_turn();
        // partners out of range skip averaging, so entry 0 is a whole turn
        send_item(make_load(5'd0, 32'hFFFF_FFFF, 5'd31));
        send_item(make_load(5'd1, 32'h0, 5'd31));
        send_item(make_op(OP_PREPARE, 32'h0));
        send_item(make_op(OP_QUERY, 32'h0));
        send_item(make_op(OP_QUERY, 32'h1));
        send_item(make_op(OP_QUERY, 32'hFFFF_FFFF));
    endtask

    task automatic test_count_sweep();
        logic [5:0] values[7] = '{6'd0, 6'd1, 6'd3, 6'd32, 6'd63, 6'd17, 6'd2};
        foreach (values[v]) begin
            write_count(values[v]);
            send_item(make_op(OP_PREPARE, $urandom));
            repeat (4) send_item(make_op(OP_QUERY, pick_point()));
        end
    endtask

    task automatic test_backpressure();
        go_idle();
        rx_hold_cycles = 600;
        repeat (12) send_item(make_op(OP_QUERY, pick_point()));
    endtask

    task automatic test_random_mix();
        int unsigned r;
        logic [5:0] counts[6] = '{6'd2, 6'd32, 6'd8, 6'd13, 6'd63, 6'd1};
        for (int unsigned j = 0; j < 1000; j++) begin
            if (j % 180 == 179) begin
                write_count(counts[$urandom_range(0, 5)]);
                send_item(make_op(OP_PREPARE, $urandom));
            end
            r = $urandom_range(0, 99);
            if (r < 38)
                send_item(make_load(5'($urandom), ($urandom_range(0, 9) == 0) ?
                                    (($urandom_range(0, 1) != 0) ? 32'h0 : 32'hFFFF_FFFF) :
                                    $urandom,
                                    ($urandom_range(0, 3) == 0) ? 5'($urandom) :
                                                                  5'($urandom % 8)));
            else if (r < 42)
                send_item(make_op(OP_PREPARE, $urandom));
            else if (r < 46)
                send_item(make_op(OP_UNUSED, $urandom));
            else
                send_item(make_op(OP_QUERY, pick_point()));
        end
    endtask

    // Receiver stall pattern, with a long hold when requested
    always @(posedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            rx_hold_cycles <= rx_hold_cycles - 1;
        end else if ($urandom_range(0, 63) == 0) begin
            rx_quiet <= ~rx_quiet;
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= rx_quiet ? 1'b0 : ($urandom_range(0, 9) < 4);
        end
    end

    logic      seen_valid;
    logic      seen_stall;
    t_out_item seen_data;

    always @(negedge i_clk) begin
        seen_valid = o_out_valid;
        seen_stall = i_out_stall;
        seen_data = o_out_data;
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && seen_valid && !seen_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction");
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (seen_data.interval_index !== want.interval_index) begin
                    $error("interval_index: expected %0d, got %0d",
                           want.interval_index, seen_data.interval_index);
                    fail_count++;
                end
                if (seen_data.image_point !== want.image_point) begin
                    $error("image_point: expected %h, got %h",
                           want.image_point, seen_data.image_point);
                    fail_count++;
                end
                if (seen_data.on_division_point !== want.on_division_point) begin
                    $error("on_division_point: expected %0d, got %0d",
                           want.on_division_point, seen_data.on_division_point);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        fail_count = 0;
        burst_left = 0;
        rx_hold_cycles = 0;
        rx_quiet = 1'b0;
        seen_valid = 1'b0;
        seen_stall = 1'b0;
        seen_data = '0;
        count_reg = 6'd2;
        len_sum = '0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_full_load();
        test_zero_total();
        test_full_turn();
        test_count_sweep();
        test_backpressure();
        test_random_mix();

        go_idle();
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/clim_pkg.sv
sv/circle_leaf_interval_map_core.sv
tb/tb_circle_leaf_interval_map_core.sv
